### sv/bresenham_line_rasterizer_top_macros.svh
// Assertion macros for the line rasteriser checker.
// Used by blr_checker only; no other dependencies.
`ifndef BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define BLR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("blr check failed");

// next-cycle implication, disabled in reset
`define BLR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("blr check failed");

`endif

### sv/blr_pkg.sv
// Types and constants shared by the line rasteriser modules.
// No dependencies.
package blr_pkg;

    localparam int unsigned COORD_W = 6;
    localparam int unsigned ERR_W   = 8;
    localparam int unsigned BYTE_W  = 9;
    localparam int unsigned BIT_W   = 3;
    localparam int unsigned OP_W    = 2;

    localparam logic [OP_W-1:0] OP_SET      = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd1;
    localparam logic [OP_W-1:0] OP_TOGGLE   = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
        logic flush;
    } t_blr_cmd;

    typedef struct packed {
        logic at_end;
        logic onscreen;
        logic pend_valid;
        logic out_free;
    } t_blr_status;

endpackage

### sv/bresenham_line_rasterizer_top.sv
// Bresenham line rasteriser: turns line requests into a stream of pixels.
// Depends on blr_pkg, blr_ctrl and blr_datapath.
//
// Slave side takes one line request: two endpoints and a draw operation
// (set, clear, toggle; the unused code draws as toggle). Master side gives
// one request per pixel drawn, with its page-organised frame-buffer byte,
// bit number and operation; tlast marks the final pixel of the line.
// The endpoint last on the major axis is not drawn; off-screen pixels are dropped.
// A zero-length or fully clipped line gives no output at all.
//
// Sequence: a line request is taken in the idle state, set up in the next
// cycle, then walked at one major-axis step per cycle unless an on-screen
// step must wait for the output register, then flushed once that is free.
// Each pixel is held in a pending register until the next on-screen pixel
// or the flush moves it to the output register, so that tlast can be placed.
// The next request is taken once the flush is done, even while the last
// pixel still waits in the output register. A stalled receiver holds the
// output register and halts the walk at any on-screen step that would push
// a pixel; off-screen steps go on.
// Reset (synchronous, active low) empties the block and returns it to idle.
module bresenham_line_rasterizer_top
    import blr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // start_x, start_y, end_x, end_y
    input  logic [1:0]  i_s_axis_tuser,  // draw_op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // pixel_x, pixel_y, byte_index, bit_index
    output logic [1:0]  o_m_axis_tuser,  // pixel_op
    output logic        o_m_axis_tlast
);

    t_blr_cmd    cmd;
    t_blr_status st;

    logic [COORD_W-1:0] pixel_x, pixel_y;
    logic [BYTE_W-1:0]  byte_index;
    logic [BIT_W-1:0]   bit_index;

    blr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    blr_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_start_x    (i_s_axis_tdata[5:0]),
        .i_start_y    (i_s_axis_tdata[11:6]),
        .i_end_x      (i_s_axis_tdata[17:12]),
        .i_end_y      (i_s_axis_tdata[23:18]),
        .i_draw_op    (i_s_axis_tuser),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_pixel_x    (pixel_x),
        .o_pixel_y    (pixel_y),
        .o_byte_index (byte_index),
        .o_bit_index  (bit_index),
        .o_pixel_op   (o_m_axis_tuser),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {bit_index, byte_index, pixel_y, pixel_x};

endmodule

### sv/blr_ctrl.sv
// Sequencer for the line rasteriser: accept, set up, walk, flush.
// Depends on blr_pkg.
module blr_ctrl
    import blr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_blr_status i_st,
    output t_blr_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (i_st.at_end) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!i_st.pend_valid || i_st.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            ST_WALK: begin
                // off-screen steps never need the output; on-screen ones may stall
                o_cmd.step = !i_st.at_end &&
                             (!i_st.onscreen || !i_st.pend_valid || i_st.out_free);
            end
            ST_FLUSH: begin
                o_cmd.flush = i_st.pend_valid && i_st.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### sv/blr_datapath.sv
// Line walk datapath: endpoint ordering, error term, pending pixel, output register.
// Depends on blr_pkg.
module blr_datapath
    import blr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_blr_cmd           i_cmd,
    output t_blr_status        o_st,
    input  logic [COORD_W-1:0] i_start_x,
    input  logic [COORD_W-1:0] i_start_y,
    input  logic [COORD_W-1:0] i_end_x,
    input  logic [COORD_W-1:0] i_end_y,
    input  logic [OP_W-1:0]    i_draw_op,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [COORD_W-1:0] o_pixel_x,
    output logic [COORD_W-1:0] o_pixel_y,
    output logic [BYTE_W-1:0]  o_byte_index,
    output logic [BIT_W-1:0]   o_bit_index,
    output logic [OP_W-1:0]    o_pixel_op,
    output logic               o_last
);

    localparam logic [COORD_W:0] W_LIM = (COORD_W+1)'(SCREEN_WIDTH);
    localparam logic [COORD_W:0] H_LIM = (COORD_W+1)'(SCREEN_HEIGHT);
    localparam logic [BYTE_W-1:0] W_BYTES = BYTE_W'(SCREEN_WIDTH);

    logic [COORD_W-1:0] r_ax, r_ay, r_bx, r_by;
    logic [OP_W-1:0]    r_op;

    logic [COORD_W-1:0] r_x, r_y, r_end, r_dx, r_dy;
    logic signed [ERR_W-1:0] r_err;
    logic               r_up;
    logic               r_steep;

    logic               r_pend_valid;
    logic [COORD_W-1:0] r_pend_x, r_pend_y;

    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x, r_out_y;
    logic [BYTE_W-1:0]  r_out_byte;
    logic [BIT_W-1:0]   r_out_bit;
    logic [OP_W-1:0]    r_out_op;
    logic               r_out_last;

    // setup
    logic [COORD_W-1:0] adx, ady, mx0, my0, mx1, my1, sx0, sy0, sx1, sy1;
    logic [COORD_W-1:0] major_span;
    logic               steep, swap;

    always_comb begin
        adx   = (r_bx > r_ax) ? (r_bx - r_ax) : (r_ax - r_bx);
        ady   = (r_by > r_ay) ? (r_by - r_ay) : (r_ay - r_by);
        steep = ady > adx;
        mx0   = steep ? r_ay : r_ax;
        my0   = steep ? r_ax : r_ay;
        mx1   = steep ? r_by : r_bx;
        my1   = steep ? r_bx : r_by;
        swap  = mx0 > mx1;
        sx0   = swap ? mx1 : mx0;
        sy0   = swap ? my1 : my0;
        sx1   = swap ? mx0 : mx1;
        sy1   = swap ? my0 : my1;
        major_span = sx1 - sx0;
    end

    // walk step
    logic [COORD_W-1:0] px, py;
    logic               onscreen;
    logic signed [ERR_W-1:0] err_sub;
    logic               push;
    logic               out_free;

    assign px       = r_steep ? r_y : r_x;
    assign py       = r_steep ? r_x : r_y;
    assign onscreen = ({1'b0, px} < W_LIM) && ({1'b0, py} < H_LIM);
    assign err_sub  = r_err - $signed({{(ERR_W-COORD_W){1'b0}}, r_dy});
    assign out_free = !r_out_valid || i_out_ready;
    assign push     = (i_cmd.step && onscreen && r_pend_valid) || i_cmd.flush;

    assign o_st.at_end     = (r_x == r_end);
    assign o_st.onscreen   = onscreen;
    assign o_st.pend_valid = r_pend_valid;
    assign o_st.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax <= i_start_x;
            r_ay <= i_start_y;
            r_bx <= i_end_x;
            r_by <= i_end_y;
            r_op <= (i_draw_op == OP_RESERVED) ? OP_TOGGLE : i_draw_op;
        end
        if (i_cmd.setup) begin
            r_steep <= steep;
            r_x     <= sx0;
            r_y     <= sy0;
            r_end   <= sx1;
            r_dx    <= sx1 - sx0;
            r_dy    <= (sy1 > sy0) ? (sy1 - sy0) : (sy0 - sy1);
            r_up    <= sy0 < sy1;
            r_err   <= $signed({{(ERR_W-COORD_W+1){1'b0}}, major_span[COORD_W-1:1]});
        end else if (i_cmd.step) begin
            r_x <= r_x + 1'b1;
            if (err_sub < 0) begin
                r_y   <= r_up ? (r_y + 1'b1) : (r_y - 1'b1);
                r_err <= err_sub + $signed({{(ERR_W-COORD_W){1'b0}}, r_dx});
            end else begin
                r_err <= err_sub;
            end
        end
        if (i_cmd.step && onscreen) begin
            r_pend_x <= px;
            r_pend_y <= py;
        end
        if (push) begin
            r_out_x    <= r_pend_x;
            r_out_y    <= r_pend_y;
            r_out_byte <= {{(BYTE_W-COORD_W){1'b0}}, r_pend_x}
                          + ({{(BYTE_W-BIT_W){1'b0}}, r_pend_y[COORD_W-1:BIT_W]} * W_BYTES);
            r_out_bit  <= r_pend_y[BIT_W-1:0];
            r_out_op   <= r_op;
            r_out_last <= i_cmd.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.step && onscreen) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_out_x;
    assign o_pixel_y    = r_out_y;
    assign o_byte_index = r_out_byte;
    assign o_bit_index  = r_out_bit;
    assign o_pixel_op   = r_out_op;
    assign o_last       = r_out_last;

endmodule

### sv/blr_checker.sv
// Port-level checks for the line rasteriser, bound to the top level.
// Depends on blr_pkg and bresenham_line_rasterizer_top_macros.svh.
`include "bresenham_line_rasterizer_top_macros.svh"

module blr_checker
    import blr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 48
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    `BLR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
        && $stable(o_m_axis_tlast))
    `BLR_ASSERT_NEXT(a_one_line, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready,
        !o_s_axis_tready)
    `BLR_ASSERT_NOW(a_on_screen, i_clk, i_rst_n, o_m_axis_tvalid,
        ({26'd0, o_m_axis_tdata[5:0]} < SCREEN_WIDTH)
        && ({26'd0, o_m_axis_tdata[11:6]} < SCREEN_HEIGHT)
        && (o_m_axis_tdata[23:21] == o_m_axis_tdata[8:6]))
    `BLR_ASSERT_NOW(a_op_known, i_clk, i_rst_n, o_m_axis_tvalid,
        o_m_axis_tuser != OP_RESERVED)

endmodule

bind bresenham_line_rasterizer_top blr_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_blr_checker (.*);

### tb/tb_bresenham_line_rasterizer_top.sv
// Self-checking testbench for bresenham_line_rasterizer_top: line requests in, pixels out.
// Depends on blr_pkg and the rasteriser RTL; expected pixels are worked out by an
// in-bench line walker and checked in order against each accepted output request.
module tb_bresenham_line_rasterizer_top
    import blr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_W      = 64;
    localparam int SCREEN_H      = 48;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 80;

    typedef struct {
        logic [5:0] x;
        logic [5:0] y;
        logic [8:0] byte_idx;
        logic [2:0] bit_idx;
        logic [1:0] op;
        logic       last;
    } t_pixel;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;   // start_x, start_y, end_x, end_y
    logic [1:0]  i_s_axis_tuser;   // draw_op
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;   // pixel_x, pixel_y, byte_index, bit_index
    logic [1:0]  o_m_axis_tuser;   // pixel_op
    logic        o_m_axis_tlast;

    t_pixel pixel_q[$];
    int     mismatches  = 0;
    int     stuck_cycles = 0;
    int     stall_left  = 0;
    bit     feed_gaps   = 1'b1;
    bit     sink_stalls = 1'b1;

    bresenham_line_rasterizer_top #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int span(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // mostly short, now and then long
    function automatic int pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    // walks one line and queues the pixels it should produce
    function automatic void plot_line(input logic [5:0] sx, input logic [5:0] sy,
                                      input logic [5:0] ex, input logic [5:0] ey,
                                      input logic [1:0] op);
        int     ax, ay, bx, by, t, dx, dy, err, ystep, px, py;
        bit     steep;
        t_pixel p;
        t_pixel line_q[$];
        ax = int'(sx);
        ay = int'(sy);
        bx = int'(ex);
        by = int'(ey);
        steep = span(by, ay) > span(bx, ax);
        if (steep) begin
            t = ax; ax = ay; ay = t;
            t = bx; bx = by; by = t;
        end
        if (ax > bx) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        dx    = bx - ax;
        dy    = span(by, ay);
        err   = dx / 2;
        ystep = (ay < by) ? 1 : -1;
        for (; ax < bx; ax++) begin
            px = steep ? ay : ax;
            py = steep ? ax : ay;
            if (px >= 0 && py >= 0 && px < SCREEN_W && py < SCREEN_H) begin
                p.x        = px[5:0];
                p.y        = py[5:0];
                p.byte_idx = 9'(px + (py / 8) * SCREEN_W);
                p.bit_idx  = 3'(py % 8);
                p.op       = (op == OP_RESERVED) ? OP_TOGGLE : op;
                p.last     = 1'b0;
                line_q.push_back(p);
            end
            err -= dy;
            if (err < 0) begin
                ay  += ystep;
                err += dx;
            end
        end
        if (line_q.size() > 0) begin
            p      = line_q.pop_back();
            p.last = 1'b1;
            line_q.push_back(p);
        end
        foreach (line_q[i]) pixel_q.push_back(line_q[i]);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: pixel %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // request monitor and pixel checker
    always @(posedge i_clk) begin : monitor
        t_pixel want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                plot_line(i_s_axis_tdata[5:0], i_s_axis_tdata[11:6], i_s_axis_tdata[17:12],
                          i_s_axis_tdata[23:18], i_s_axis_tuser);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected pixel, expected none, got x=%0d y=%0d",
                             $time, o_m_axis_tdata[5:0], o_m_axis_tdata[11:6]);
                    mismatches++;
                end else begin
                    want = pixel_q.pop_front();
                    check_field("x",    int'(want.x),        int'(o_m_axis_tdata[5:0]));
                    check_field("y",    int'(want.y),        int'(o_m_axis_tdata[11:6]));
                    check_field("byte", int'(want.byte_idx), int'(o_m_axis_tdata[20:12]));
                    check_field("bit",  int'(want.bit_idx),  int'(o_m_axis_tdata[23:21]));
                    check_field("op",   int'(want.op),       int'(o_m_axis_tuser));
                    check_field("last", int'(want.last),     int'(o_m_axis_tlast));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
            stall_left = pick_gap() - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stuck_cycles = 0;
        end else if (stuck_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stuck_cycles++;
        end
    end

    task automatic send_line(input logic [5:0] sx, input logic [5:0] sy,
                             input logic [5:0] ex, input logic [5:0] ey,
                             input logic [1:0] op);
        int gap;
        gap = (feed_gaps && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {ey, ex, sy, sx};
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic wait_all_drawn();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pixel_q.size() != 0);
    endtask

    task automatic send_random_line(input bit short_only);
        int sx, sy, ex, ey, kind;
        kind = short_only ? 6 : $urandom_range(0, 9);
        sx = $urandom_range(0, 63);
        sy = $urandom_range(0, 47);
        if (kind < 6) begin
            ex = $urandom_range(0, 63);
            ey = $urandom_range(0, 47);
        end else if (kind < 8) begin
            ex = sx + $urandom_range(0, 6) - 3;
            ey = sy + $urandom_range(0, 6) - 3;
            ex = (ex < 0) ? 0 : (ex > 63) ? 63 : ex;
            ey = (ey < 0) ? 0 : (ey > 47) ? 47 : ey;
        end else begin
            sy = $urandom_range(0, 63);
            ex = $urandom_range(0, 63);
            ey = $urandom_range(0, 63);
        end
        send_line(6'(sx), 6'(sy), 6'(ex), 6'(ey), 2'($urandom_range(0, 3)));
    endtask

    task automatic test_directed_lines();
        feed_gaps   = 1'b1;
        sink_stalls = 1'b1;
        send_line(6'd0,  6'd0,  6'd63, 6'd47, OP_SET);
        send_line(6'd63, 6'd47, 6'd0,  6'd0,  OP_CLEAR);
        send_line(6'd0,  6'd0,  6'd63, 6'd0,  OP_TOGGLE);
        send_line(6'd0,  6'd47, 6'd0,  6'd0,  OP_RESERVED);
        send_line(6'd0,  6'd0,  6'd47, 6'd47, OP_SET);
        send_line(6'd10, 6'd20, 6'd11, 6'd20, OP_CLEAR);
        send_line(6'd5,  6'd5,  6'd6,  6'd47, OP_SET);
        send_line(6'd40, 6'd3,  6'd2,  6'd30, OP_TOGGLE);
        send_line(6'd63, 6'd0,  6'd0,  6'd47, OP_SET);
    endtask

    task automatic test_clipped_lines();
        send_line(6'd9,  6'd9,  6'd9,  6'd9,  OP_SET);
        send_line(6'd63, 6'd63, 6'd63, 6'd63, OP_CLEAR);
        send_line(6'd0,  6'd40, 6'd63, 6'd63, OP_TOGGLE);
        send_line(6'd0,  6'd50, 6'd63, 6'd63, OP_SET);
        send_line(6'd63, 6'd63, 6'd0,  6'd0,  OP_RESERVED);
        send_line(6'd20, 6'd63, 6'd21, 6'd0,  OP_CLEAR);
        send_line(6'd0,  6'd48, 6'd63, 6'd48, OP_SET);
        send_line(6'd30, 6'd48, 6'd30, 6'd47, OP_TOGGLE);
    endtask

    task automatic test_random_with_idling(input int count);
        feed_gaps   = 1'b1;
        sink_stalls = 1'b1;
        repeat (count) send_random_line(1'b0);
    endtask

    task automatic test_random_streaming(input int count);
        feed_gaps   = 1'b0;
        sink_stalls = 1'b0;
        repeat (count) send_random_line(1'b0);
    endtask

    task automatic test_short_lines(input int count);
        feed_gaps   = 1'b1;
        sink_stalls = 1'b1;
        repeat (count) send_random_line(1'b1);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= '0;
        i_m_axis_tready <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_lines();
        wait_all_drawn();
        test_clipped_lines();
        wait_all_drawn();
        test_random_with_idling(200);
        wait_all_drawn();
        test_random_streaming(150);
        test_short_lines(100);

        wait_all_drawn();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pixel_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
